[sv/baro_temp_pressure_compensate_core_assert.svh]
// Assertion macros for the compensation core.
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_CORE_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BTPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BTPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/btpc_pkg.sv]
// Package with shared types and constants for the compensation core.
package btpc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_B1_B2 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MC_MD = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OSS = 3'd5;
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_TDIV, S_T3,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_PDIV, S_P10, S_P11, S_P12, S_P13, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction
endpackage

[sv/btpc_stream_if.sv]
// Valid/ready stream interface.
interface btpc_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/btpc_div.sv]
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module btpc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  btpc_pkg::div_req_t req,
  output btpc_pkg::div_rsp_t rsp
);
  import btpc_pkg::*;
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.num; d_nxt = req.den; rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DivSteps - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  logic busy_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_d_r <= 1'b0;
    else busy_d_r <= busy_r;
  end
  assign rsp.done = busy_d_r && !busy_r;
  assign rsp.quo  = q_r;

  `include "baro_temp_pressure_compensate_core_assert.svh"
  `BTPC_ASSERT_IMP(a_cnt_range, busy_r, cnt_r < 6'(DivSteps))
  `BTPC_ASSERT_NEXT(a_start_busy, req.start, busy_r)
  `BTPC_ASSERT_IMP(a_done_idle, rsp.done, !busy_r)
endmodule

[sv/baro_temp_pressure_compensate_core.sv]
// Top level: sequencer around one shared multiplier and a serial divider.
// Usage: write calibration words and oversampling through cfg_* while idle
// (cfg_index 0..4 coefficients, 5 oversampling). Then send requests on the
// in channel: opcode 0 with raw temperature in raw_value[15:0], or opcode 1
// with the 24-bit raw pressure. Each request yields one result on out.
// Temperature stores B5 for later pressure requests.
// Each request runs through the temperature or pressure states in order,
// with at most one multiply step per cycle on the shared 32x32 multiplier
// and a wait on the serial divider; a zero divisor skips the divide. One
// request is in flight at a time; in_ready is low from acceptance until its
// result is taken. A stalled receiver holds the result in the output
// register and blocks new requests.
// Reset clears the coefficients to 0, oversampling to 1 and B5 to 0.
// A zero divisor sets divide_fault and gives a zero value.
module baro_temp_pressure_compensate_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [btpc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [btpc_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [23:0]                       in_raw_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_kind,
  output logic signed [15:0]                out_temperature,
  output logic [17:0]                       out_pressure,
  output logic                              out_divide_fault
);
  import btpc_pkg::*;

  logic [31:0] c0_r, c1_r, c2_r, c3_r, c4_r;
  logic [1:0]  oss_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0; c1_r <= '0; c2_r <= '0; c3_r <= '0; c4_r <= '0; oss_r <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AC1_AC2: c0_r <= cfg_data;
        REG_AC3_AC4: c1_r <= cfg_data;
        REG_AC5_AC6: c2_r <= cfg_data;
        REG_B1_B2:   c3_r <= cfg_data;
        REG_MC_MD:   c4_r <= cfg_data;
        REG_OSS:     oss_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] sx(input logic [15:0] v);
    sx = {{16{v[15]}}, v};
  endfunction
  wire [31:0] ac1 = sx(c0_r[31:16]), ac2 = sx(c0_r[15:0]);
  wire [31:0] ac3 = sx(c1_r[31:16]), ac4 = {16'd0, c1_r[15:0]};
  wire [31:0] ac5 = {16'd0, c2_r[31:16]}, ac6 = {16'd0, c2_r[15:0]};
  wire [31:0] b1 = sx(c3_r[31:16]), b2 = sx(c3_r[15:0]);
  wire [31:0] mc = sx(c4_r[31:16]), md = sx(c4_r[15:0]);

  state_t state_r, state_nxt;
  logic [31:0] b5_r, b5_nxt;
  logic [23:0] raw_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r, p_r; // working registers
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, p_nxt;
  logic        neg_r, neg_nxt, fault_r, fault_nxt;
  logic [31:0] ma, mb, prod;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign prod = 32'(ma * mb);

  btpc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  wire in_acc  = in_valid && in_ready;
  wire out_acc = out_valid && out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (in_opcode == OP_TEMP) ? S_T0 : S_P0;
      S_T0:    state_nxt = S_T1;
      S_T1:    state_nxt = S_T2;
      S_T2:    state_nxt = fault_nxt ? S_T3 : S_TDIV;
      S_TDIV:  if (drsp.done) state_nxt = S_T3;
      S_T3:    state_nxt = S_OUT;
      S_P0:    state_nxt = S_P1;
      S_P1:    state_nxt = S_P2;
      S_P2:    state_nxt = S_P3;
      S_P3:    state_nxt = S_P4;
      S_P4:    state_nxt = S_P5;
      S_P5:    state_nxt = S_P6;
      S_P6:    state_nxt = S_P7;
      S_P7:    state_nxt = S_P8;
      S_P8:    state_nxt = S_P9;
      S_P9:    state_nxt = fault_nxt ? S_OUT : S_PDIV;
      S_PDIV:  if (drsp.done) state_nxt = S_P10;
      S_P10:   state_nxt = S_P11;
      S_P11:   state_nxt = S_P12;
      S_P12:   state_nxt = S_P13;
      S_P13:   state_nxt = S_OUT;
      S_OUT:   if (out_acc) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath: at most one multiply per state into the working registers.
  always_comb begin
    logic [31:0] up, t, b3, x3, p8;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r; p_nxt = p_r;
    b5_nxt = b5_r; neg_nxt = neg_r; fault_nxt = fault_r;
    ma = '0; mb = '0; dreq = '0;
    up = 32'(raw_r) >> (4'd8 - {2'b0, oss_r});
    b3 = '0; x3 = '0; t = '0;
    p8 = asr(p_r, 5'd8);
    unique case (state_r)
      S_IDLE: begin fault_nxt = 1'b0; end
      S_T0: begin
        ma = {16'd0, raw_r[15:0]} - ac6; mb = ac5;
        a_nxt = asr(prod, 5'd15);               // X1
      end
      S_T1: begin
        b_nxt = a_r + md;                        // denominator
        c_nxt = mc << 11;                        // numerator
      end
      S_T2: begin
        fault_nxt = (b_r == '0);
        neg_nxt = c_r[31] ^ b_r[31];
        dreq.start = (b_r != '0);
        dreq.num = c_r[31] ? -c_r : c_r;
        dreq.den = b_r[31] ? -b_r : b_r;
        d_nxt = '0;
      end
      S_TDIV: if (drsp.done) d_nxt = neg_r ? -drsp.quo : drsp.quo;
      S_T3: begin
        b5_nxt = a_r + d_r;
        t = asr(a_r + d_r + 32'd8, 5'd4);
        if (fault_r) e_nxt = '0;
        else if ($signed(t) > 32'sd32767) e_nxt = 32'd32767;
        else if ($signed(t) < -32'sd32768) e_nxt = 32'hFFFF8000;
        else e_nxt = t;
        p_nxt = '0;
      end
      S_P0: begin
        a_nxt = b5_r - 32'd4000;                 // B6
      end
      S_P1: begin ma = a_r; mb = a_r; b_nxt = asr(prod, 5'd12); end   // sq
      S_P2: begin ma = b2; mb = b_r; c_nxt = asr(prod, 5'd11); end
      S_P3: begin ma = ac2; mb = a_r; d_nxt = asr(prod, 5'd11); end
      S_P4: begin
        x3 = c_r + d_r;
        b3 = asr(((ac1 << 2) + x3 << oss_r) + 32'd2, 5'd2);
        e_nxt = up - b3;                         // UP - B3
      end
      S_P5: begin ma = ac3; mb = a_r; c_nxt = asr(prod, 5'd13); end
      S_P6: begin ma = b1; mb = b_r; d_nxt = asr(prod, 5'd16); end
      S_P7: begin
        x3 = asr(c_r + d_r + 32'd2, 5'd2);
        ma = ac4; mb = x3 + 32'd32768;
        b_nxt = prod >> 15;                      // B4
      end
      S_P8: begin ma = e_r; mb = 32'd50000 >> oss_r; c_nxt = prod; end // B7
      S_P9: begin
        fault_nxt = (b_r == '0);
        neg_nxt = c_r[31];                       // doubles after divide
        dreq.start = (b_r != '0);
        dreq.num = c_r[31] ? c_r : c_r << 1;
        dreq.den = b_r;
        e_nxt = '0; p_nxt = '0;
      end
      S_PDIV: if (drsp.done) p_nxt = neg_r ? drsp.quo << 1 : drsp.quo;
      S_P10: begin ma = p8; mb = p8; a_nxt = prod; end
      S_P11: begin ma = a_r; mb = 32'd3038; a_nxt = asr(prod, 5'd16); end
      S_P12: begin ma = -32'd7357; mb = p_r; d_nxt = asr(prod, 5'd16); end
      S_P13: begin
        t = p_r + asr(a_r + d_r + 32'd3791, 5'd4);
        if (t[31]) p_nxt = '0;
        else if (t > 32'd262143) p_nxt = 32'd262143;
        else p_nxt = t;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  logic kind_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; b5_r <= '0; fault_r <= 1'b0;
    end else begin
      state_r <= state_nxt; b5_r <= b5_nxt; fault_r <= fault_nxt;
    end
    if (in_acc) begin raw_r <= in_raw_value; kind_r <= in_opcode; end
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
    p_r <= p_nxt; neg_r <= neg_nxt;
  end

  assign out_result_kind  = kind_r;
  assign out_temperature  = (kind_r == OP_TEMP) ? e_r[15:0] : 16'sd0;
  assign out_pressure     = (kind_r == OP_PRES && !fault_r) ? p_r[17:0] : 18'd0;
  assign out_divide_fault = fault_r;

  `include "baro_temp_pressure_compensate_core_assert.svh"
  `BTPC_ASSERT_IMP(a_not_both, in_ready, !out_valid)
  `BTPC_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid)
  `BTPC_ASSERT_IMP(a_fault_zero, out_valid && out_divide_fault,
                   out_pressure == 18'd0 && out_temperature == 16'sd0)
endmodule

[tb/sv/tb_baro_temp_pressure_compensate_checker.sv]
// Checker: mirrors the calibration registers, predicts each result and compares it.
module tb_baro_temp_pressure_compensate_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [btpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [btpc_pkg::CfgDataW-1:0] cfg_data,
  btpc_stream_if                        req,
  btpc_stream_if                        res,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] temp;
    logic [17:0]        pres;
    logic               fault;
  } reading_t;

  localparam logic [31:0] B6Offset   = 32'd4000;
  localparam logic [31:0] B4Bias     = 32'd32768;
  localparam logic [31:0] B7Scale    = 32'd50000;
  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] PolySq     = 32'd3038;
  localparam logic [31:0] PolyLin    = 32'd7357;
  localparam logic [31:0] PolyOffset = 32'd3791;

  logic [31:0] coef_words [5];
  logic [1:0]  oss_mirror;
  logic [31:0] b5_store;
  reading_t    expected_readings [$];

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Updates b5_store for temperature requests.
  function automatic reading_t predict_reading(input logic op, input logic [23:0] raw);
    reading_t    r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b6, sq, b3, b4, b7, p, pw;
    longint      q, tv, pv;
    ac1 = sx16(coef_words[REG_AC1_AC2][31:16]);
    ac2 = sx16(coef_words[REG_AC1_AC2][15:0]);
    ac3 = sx16(coef_words[REG_AC3_AC4][31:16]);
    ac4 = {16'd0, coef_words[REG_AC3_AC4][15:0]};
    ac5 = {16'd0, coef_words[REG_AC5_AC6][31:16]};
    ac6 = {16'd0, coef_words[REG_AC5_AC6][15:0]};
    b1  = sx16(coef_words[REG_B1_B2][31:16]);
    b2  = sx16(coef_words[REG_B1_B2][15:0]);
    mc  = sx16(coef_words[REG_MC_MD][31:16]);
    md  = sx16(coef_words[REG_MC_MD][15:0]);
    r = '0;
    r.kind = op;
    if (op == OP_TEMP) begin
      ut = {16'd0, raw[15:0]};
      x1 = sra((ut - ac6) * ac5, 15);
      den = x1 + md;
      x2 = '0;
      if (den == 0) begin
        r.fault = 1'b1;
      end else begin
        pw = mc << 11;
        q = longint'($signed(pw)) / longint'($signed(den));
        x2 = q[31:0];
      end
      b5_store = x1 + x2;
      if (!r.fault) begin
        tv = longint'($signed(sra(b5_store + 32'd8, 4)));
        if (tv > 32767) tv = 32767;
        if (tv < -32768) tv = -32768;
        r.temp = tv[15:0];
      end
    end else begin
      up = {8'd0, raw} >> (8 - oss_mirror);
      b6 = b5_store - B6Offset;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra(((ac1 * 32'd4 + x3) << oss_mirror) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + B4Bias)) >> 15;
      b7 = (up - b3) * (B7Scale >> oss_mirror);
      if (b4 == 0) begin
        r.fault = 1'b1;
      end else begin
        if (b7 < SignBit) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * PolySq, 16);
        x2 = sra((32'd0 - PolyLin) * p, 16);
        p = p + sra(x1 + x2 + PolyOffset, 4);
        pv = longint'($signed(p));
        if (pv < 0) pv = 0;
        if (pv > 262143) pv = 262143;
        r.pres = pv[17:0];
      end
    end
    return r;
  endfunction

  assign pending = expected_readings.size();

  always @(posedge clk) begin
    reading_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) coef_words[i] <= '0;
      oss_mirror <= 2'd1;
      b5_store = '0;
      expected_readings.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < REG_OSS) coef_words[cfg_index] <= cfg_data;
        else if (cfg_index == REG_OSS) oss_mirror <= cfg_data[1:0];
      end
      if (req.valid && req.ready)
        expected_readings.push_back(predict_reading(req.data[24], req.data[23:0]));
      if (res.valid && res.ready) begin
        got = res.data;
        if (expected_readings.size() == 0) begin
          if (fail_count < 10) $display("[%0t] unexpected result %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: kind %0d/%0d temp %0d/%0d pres %0d/%0d fault %0d/%0d",
                       $realtime, want.kind, got.kind, want.temp, got.temp,
                       want.pres, got.pres, want.fault, got.fault);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/sv/tb_baro_temp_pressure_compensate_core.sv]
// Testbench top: drives calibration, requests and result stalls, and gives the verdict.
module tb_baro_temp_pressure_compensate_core;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam logic [31:0] StdAc12 = {16'd408, 16'hFFB8};
  localparam logic [31:0] StdAc34 = {16'hC7D1, 16'd32741};
  localparam logic [31:0] StdAc56 = {16'd32757, 16'd23153};
  localparam logic [31:0] StdB12  = {16'd6190, 16'd4};
  localparam logic [31:0] StdMcMd = {16'hDDF9, 16'd2868};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count, pending;
  int burst_left = 0;
  logic [1:0] oss_now = 2'd1;

  btpc_stream_if #(.W(25)) req_ch ();
  btpc_stream_if #(.W(36)) res_ch ();

  logic               o_kind, o_fault;
  logic signed [15:0] o_temp;
  logic [17:0]        o_pres;
  assign res_ch.data = {o_kind, o_temp, o_pres, o_fault};

  baro_temp_pressure_compensate_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .in_opcode(req_ch.data[24]), .in_raw_value(req_ch.data[23:0]),
    .out_valid(res_ch.valid), .out_ready(res_ch.ready),
    .out_result_kind(o_kind), .out_temperature(o_temp),
    .out_pressure(o_pres), .out_divide_fault(o_fault)
  );

  tb_baro_temp_pressure_compensate_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch), .res(res_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Receiver: stall behavior switches at random between always, mostly and rarely ready.
  int stall_mode = 0, mode_cycles = 0;
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_cycles <= $urandom_range(50, 400);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: res_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_OSS) oss_now = val[1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(input logic [31:0] c0, c1, c2, c3, c4, input logic [1:0] oss);
    write_reg(REG_AC1_AC2, c0);
    write_reg(REG_AC3_AC4, c1);
    write_reg(REG_AC5_AC6, c2);
    write_reg(REG_B1_B2, c3);
    write_reg(REG_MC_MD, c4);
    write_reg(REG_OSS, {30'd0, oss});
    @(posedge clk);
  endtask

  // Called just after a rising edge; returns at acceptance or after a later idle gap.
  task automatic send_request(input logic op, input logic [23:0] raw);
    req_ch.valid <= 1'b1;
    req_ch.data <= {op, raw};
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Lets outstanding results drain so registers can be rewritten.
  task automatic drain;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] jitter(input logic [31:0] w, input int span);
    logic [15:0] hi, lo;
    hi = w[31:16] + 16'($urandom_range(0, 2 * span) - span);
    lo = w[15:0] + 16'($urandom_range(0, 2 * span) - span);
    return {hi, lo};
  endfunction

  // Mostly a temperature followed by a pressure, near realistic raw values.
  task automatic random_phase(input int count);
    logic [15:0] ut;
    logic [23:0] raw;
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) != 0) begin
        ut = 16'd27898 + 16'($urandom_range(0, 8000) - 4000);
        raw = {8'($urandom_range(0, 255)), ut} ^
              ($urandom_range(0, 7) == 0 ? 24'($urandom) : 24'd0);
        send_request(OP_TEMP, raw);
        raw = 24'((23843 + $urandom_range(0, 20000) - 10000) << (8 - oss_now));
        raw = raw ^ 24'($urandom_range(0, 255));
        send_request(OP_PRES, raw);
        n += 2;
      end else begin
        send_request(1'($urandom), 24'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    logic [31:0] w [5];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: every divisor is zero; pressure before any temperature.
    send_request(OP_PRES, 24'h5D2300);
    send_request(OP_TEMP, 24'h006CFA);
    send_request(OP_PRES, 24'hFFFFFF);
    send_request(OP_TEMP, 24'hFFFFFF);
    drain();

    // Out-of-range register indexes must be ignored.
    load_coefs(StdAc12, StdAc34, StdAc56, StdB12, StdMcMd, 2'd0);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0000_0000);
    @(posedge clk);
    send_request(OP_PRES, 24'h5D2300);
    send_request(OP_TEMP, 24'h006CFA);
    send_request(OP_PRES, 24'h5D2300);
    send_request(OP_TEMP, 24'hAB0000);
    send_request(OP_PRES, 24'h000000);
    send_request(OP_TEMP, 24'h00FFFF);
    send_request(OP_PRES, 24'hFFFFFF);
    drain();

    load_coefs(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000, 32'h8000_7FFF, 2'd3);
    send_request(OP_TEMP, 24'h000000);
    send_request(OP_PRES, 24'hFFFFFF);
    send_request(OP_TEMP, 24'hFFFFFF);
    send_request(OP_PRES, 24'h000001);
    drain();

    // Zero AC4 forces a pressure fault with otherwise sane calibration.
    load_coefs(StdAc12, 32'hC7D1_0000, StdAc56, StdB12, StdMcMd, 2'd2);
    send_request(OP_TEMP, 24'h006CFA);
    send_request(OP_PRES, 24'h174300);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin
          w[0] = StdAc12; w[1] = StdAc34; w[2] = StdAc56; w[3] = StdB12; w[4] = StdMcMd;
        end
        1: begin
          w[0] = jitter(StdAc12, 300); w[1] = jitter(StdAc34, 300);
          w[2] = jitter(StdAc56, 300); w[3] = jitter(StdB12, 300);
          w[4] = jitter(StdMcMd, 300);
        end
        2: for (int i = 0; i < 5; i++) w[i] = $urandom;
        default: for (int i = 0; i < 5; i++)
          w[i] = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_7FFF ^ $urandom_range(0, 3);
      endcase
      load_coefs(w[0], w[1], w[2], w[3], w[4], 2'(ph));
      random_phase(100);
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
